// ===== src/rbpq_pkg.sv =====
// Package for the radix bitmap priority queue: tree geometry, request and
// status codes, controller/datapath structs and bit search functions.
// No dependencies.
package rbpq_pkg;

  localparam int FANOUT_BITS    = 5;
  localparam int LEVELS         = 2;
  localparam int WORD_BITS      = 1 << FANOUT_BITS;
  localparam int KEY_BITS       = FANOUT_BITS * LEVELS;
  localparam int NUM_KEYS       = 1 << KEY_BITS;
  localparam int LEAF_WORDS     = 1 << (FANOUT_BITS * (LEVELS - 1));
  localparam int COUNT_BITS_DEF = 16;
  localparam int REQ_BITS       = 3;
  localparam int STATUS_BITS    = 2;
  localparam int RES_KEY_BITS   = 10;

  localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_MIN    = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_MAX    = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_SUCC   = 3'd4;
  localparam logic [REQ_BITS-1:0] REQ_PRED   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NONE   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd3;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [FANOUT_BITS-1:0] rank_t;
  typedef logic [KEY_BITS-1:0]    key_t;

  typedef struct packed {
    logic  found;
    rank_t idx;
  } pos_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    key_t clr_addr;
    logic upd;
    logic find1;
    logic find2;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_desc;
  } dp_stat_t;

  function automatic pos_t low_from(input word_t w);
    pos_t p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        p.found = 1'b1;
        p.idx   = FANOUT_BITS'(i);
      end
    end
    return p;
  endfunction

  function automatic pos_t high_from(input word_t w);
    pos_t p;
    p = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        p.found = 1'b1;
        p.idx   = FANOUT_BITS'(i);
      end
    end
    return p;
  endfunction

  function automatic word_t mask_above(input rank_t r);
    word_t m;
    for (int i = 0; i < WORD_BITS; i++) m[i] = (i > int'(r));
    return m;
  endfunction

  function automatic word_t mask_below(input rank_t r);
    word_t m;
    for (int i = 0; i < WORD_BITS; i++) m[i] = (i < int'(r));
    return m;
  endfunction

endpackage

// ===== src/rbpq_req_if.sv =====
// Request channel of the priority queue: valid/ready plus request fields.
// Depends on rbpq_pkg.
interface rbpq_req_if;
  logic                              valid;
  logic                              ready;
  logic [rbpq_pkg::REQ_BITS-1:0]     req_type;
  logic [rbpq_pkg::RES_KEY_BITS-1:0] key;
  logic                              strict;

  modport source (output valid, req_type, key, strict, input ready);
  modport sink   (input valid, req_type, key, strict, output ready);
endinterface

// ===== src/rbpq_rsp_if.sv =====
// Result channel of the priority queue: valid/ready plus status and key.
// Depends on rbpq_pkg.
interface rbpq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rbpq_pkg::STATUS_BITS-1:0]  status;
  logic [rbpq_pkg::RES_KEY_BITS-1:0] result_key;

  modport source (output valid, status, result_key, input ready);
  modport sink   (input valid, status, result_key, output ready);
endinterface

// ===== src/rbpq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rbpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rbpq_datapath.sv =====
// Datapath: root and leaf-parent occupancy words, entry count RAM, bit
// searches and result registers. Depends on rbpq_pkg and rbpq_ram.
module rbpq_datapath #(
  parameter int COUNT_BITS = rbpq_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbpq_pkg::dp_cmd_t                 cmd,
  output rbpq_pkg::dp_stat_t                stat,
  input  logic [rbpq_pkg::REQ_BITS-1:0]     in_req_type,
  input  logic [rbpq_pkg::RES_KEY_BITS-1:0] in_key,
  input  logic                              in_strict,
  output logic [rbpq_pkg::STATUS_BITS-1:0]  out_status,
  output logic [rbpq_pkg::RES_KEY_BITS-1:0] out_result_key
);
  import rbpq_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  word_t                  root_r, root_nxt;
  word_t                  leaf_r [LEAF_WORDS];
  logic [REQ_BITS-1:0]    req_r;
  key_t                   key_r;
  logic                   strict_r;
  rank_t                  h_r, h_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  key_t                   res_r, res_nxt;
  logic [STATUS_BITS-1:0] out_status_r;
  key_t                   out_key_r;

  rank_t                  hi, lo, lsel;
  word_t                  w, w_upd;
  logic [COUNT_BITS-1:0]  cnt, cnt_new;
  logic                   cnt_we;
  pos_t                   pa, pb, pd;
  logic                   dir_low, need_desc;

  assign hi      = key_r[KEY_BITS-1:FANOUT_BITS];
  assign lo      = key_r[FANOUT_BITS-1:0];
  assign lsel    = cmd.find2 ? h_r : hi;
  assign w       = leaf_r[lsel];
  assign dir_low = (req_r == REQ_MIN) || (req_r == REQ_SUCC);

  rbpq_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_KEYS)) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.clr_wr || cnt_we),
    .waddr (cmd.clr_wr ? cmd.clr_addr : key_r),
    .wdata (cmd.clr_wr ? '0 : cnt_new),
    .raddr (key_r),
    .rdata (cnt)
  );

  // insert / delete: count update and leaf-to-root fix
  always_comb begin
    cnt_we  = 1'b0;
    cnt_new = cnt;
    w_upd   = w;
    if (req_r == REQ_INSERT) begin
      cnt_we  = cmd.upd && (cnt != COUNT_MAX);
      cnt_new = cnt + 1'b1;
    end else begin
      cnt_we  = cmd.upd && (cnt != '0);
      cnt_new = cnt - 1'b1;
    end
    w_upd[lo] = (cnt_new != '0);
  end

  // query search: min/max search the root; successor/predecessor search the key's word first, then the root
  always_comb begin
    status_nxt = ST_OK;
    res_nxt    = '0;
    h_nxt      = h_r;
    need_desc  = 1'b0;
    pa         = '0;
    pb         = '0;
    unique case (req_r)
      REQ_MIN, REQ_MAX: begin
        pb = dir_low ? low_from(root_r) : high_from(root_r);
        if (!pb.found) status_nxt = ST_NONE;
        else begin
          h_nxt     = pb.idx;
          need_desc = 1'b1;
        end
      end
      REQ_SUCC, REQ_PRED: begin
        pa = dir_low ? low_from(w & mask_above(lo)) : high_from(w & mask_below(lo));
        pb = dir_low ? low_from(root_r & mask_above(hi))
                     : high_from(root_r & mask_below(hi));
        if (!strict_r && w[lo]) res_nxt = key_r;
        else if (pa.found) res_nxt = {hi, pa.idx};
        else if (pb.found) begin
          h_nxt     = pb.idx;
          need_desc = 1'b1;
        end else status_nxt = ST_NONE;
      end
      default: ;
    endcase
  end

  assign pd             = dir_low ? low_from(w) : high_from(w);
  assign stat.need_desc = need_desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      for (int i = 0; i < LEAF_WORDS; i++) leaf_r[i] <= '0;
    end else if (cnt_we) begin
      leaf_r[hi] <= w_upd;
      root_r     <= root_nxt;
    end
  end

  always_comb begin
    root_nxt     = root_r;
    root_nxt[hi] = (w_upd != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      key_r    <= in_key[KEY_BITS-1:0];
      strict_r <= in_strict;
    end
    if (cmd.upd) begin
      res_r <= key_r;
      if (req_r == REQ_INSERT) status_r <= (cnt == COUNT_MAX) ? ST_FULL : ST_OK;
      else                     status_r <= (cnt == '0) ? ST_ABSENT : ST_OK;
    end
    if (cmd.find1) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      h_r      <= h_nxt;
    end
    if (cmd.find2) begin
      status_r <= ST_OK;
      res_r    <= {h_r, pd.idx};
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_key_r    <= res_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_result_key = RES_KEY_BITS'(out_key_r);

endmodule

// ===== src/rbpq_ctrl.sv =====
// Controller: count-store clearing pass after reset, request sequencing and
// result valid handshake. Depends on rbpq_pkg.
module rbpq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rbpq_pkg::REQ_BITS-1:0] in_req_type,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rbpq_pkg::dp_cmd_t             cmd,
  input  rbpq_pkg::dp_stat_t            stat
);
  import rbpq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPD, S_FIND1, S_FIND2, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [KEY_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept, emit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.clr_wr   = (state_r == S_CLEAR);
    cmd.clr_addr = clr_cnt_r;
    cmd.upd      = (state_r == S_UPD);
    cmd.find1    = (state_r == S_FIND1);
    cmd.find2    = (state_r == S_FIND2);
    cmd.emit     = emit;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: if (accept) begin
        if (in_req_type == REQ_INSERT || in_req_type == REQ_DELETE) state_nxt = S_READ;
        else state_nxt = S_FIND1;
      end
      S_READ:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_DONE;
      S_FIND1: state_nxt = stat.need_desc ? S_FIND2 : S_DONE;
      S_FIND2: state_nxt = S_DONE;
      S_DONE: if (emit) begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/radix_bitmap_priority_queue_core.sv =====
// Channel   Dir  Payload                       Handshake
// in_ch     in   req_type[2:0] key[9:0] strict valid/ready
// out_ch    out  status[1:0] result_key[9:0]   valid/ready
//
// Insert/delete pass through accept, count RAM read, update and result;
// min/max/successor/predecessor take an extra step when the
// search has to descend through a second leaf-parent word.
// One request is in flight at a time; the result register lets the next
// request enter while the previous result still waits on out_ch.
// After reset the count RAM is cleared, one entry a cycle, across all 1024
// entries with in_ch.ready low.
module radix_bitmap_priority_queue_core #(
  parameter int COUNT_BITS = rbpq_pkg::COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rbpq_req_if.sink   in_ch,
  rbpq_rsp_if.source out_ch
);
  import rbpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rbpq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  rbpq_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_ch.req_type),
    .in_key         (in_ch.key),
    .in_strict      (in_ch.strict),
    .out_status     (out_ch.status),
    .out_result_key (out_ch.result_key)
  );

endmodule

// ===== src/rbpq_checker.sv =====
// Port-level checks for the priority queue core, bound to the top level.
// Depends on rbpq_pkg and radix_bitmap_priority_queue_core.
module rbpq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rbpq_pkg::STATUS_BITS-1:0]  out_status,
  input logic [rbpq_pkg::RES_KEY_BITS-1:0] out_result_key
);
  import rbpq_pkg::*;

  // a result waiting on the sink holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_key))
    else $error("result dropped or changed while stalled");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_none_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_result_key == '0)
    else $error("not-found result carries a key");

  // clearing pass: nothing taken or shown right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channel active after reset");

endmodule

bind radix_bitmap_priority_queue_core rbpq_checker u_rbpq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_result_key (out_ch.result_key)
);
